@@ design/vas_pkg.sv @@
// Shared types, codes and constants of the voice allocator.
`default_nettype none

package vas_pkg;

    localparam int NUM_VOICES_DEF = 24;

    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [31:0] HELD_BONUS_RST    = 32'd167772160;
    localparam logic [31:0] SILENCE_LEVEL_RST = 32'd17;
    localparam logic [15:0] MIN_AGE_RST       = 16'd187;
    localparam logic [15:0] MAX_AGE_RST       = 16'd9000;

    // Level 1.0 in unsigned Q8.24.
    localparam logic [31:0] LEVEL_ONE = 32'h0100_0000;
    localparam logic [15:0] AGE_MAX   = 16'hFFFF;
    localparam logic [4:0]  REL_MAX   = 5'd31;

    typedef enum logic [1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_PANIC    = 2'd2,
        CMD_REPORT   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_HELD_BONUS    = 2'd0,
        REG_SILENCE_LEVEL = 2'd1,
        REG_MIN_AGE       = 2'd2,
        REG_MAX_AGE       = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_REP_EVAL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [15:0] note;
        logic [15:0] age;
        logic [31:0] level;
    } voice_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_scan;
        logic rd_rep;
        logic rep_eval;
        logic commit;
        logic panic;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic rep_ok;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ design/vas_ctrl.sv @@
// Sequencing state machine of the voice allocator.
`default_nettype none

module vas_ctrl
    import vas_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (stat.cmd) inside
                    CMD_NOTE_ON, CMD_NOTE_OFF: state_next = ST_SCAN;
                    CMD_PANIC:                 state_next = ST_FINISH;
                    CMD_REPORT:                state_next = stat.rep_ok ? ST_REP_EVAL : ST_FINISH;
                    default:                   state_next = ST_FINISH;
                endcase
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = (stat.cmd == CMD_NOTE_ON) ? ST_COMMIT : ST_FINISH;
            end
            ST_COMMIT:
            begin
                state_next = ST_FINISH;
            end
            ST_REP_EVAL:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DISPATCH:
            begin
                cmd.panic  = (stat.cmd == CMD_PANIC);
                cmd.rd_rep = (stat.cmd == CMD_REPORT) && stat.rep_ok;
            end
            ST_SCAN:
            begin
                cmd.rd_scan = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            ST_REP_EVAL:
            begin
                cmd.rep_eval = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/vas_dp.sv @@
// Datapath of the voice allocator: voice table, scan logic, settings and result register.
`default_nettype none

module vas_dp
    import vas_pkg::*;
#(
    parameter int NUM_VOICES = NUM_VOICES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [1:0]            s_tuser,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat
);

    localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    // Settings.
    logic [31:0] held_bonus_reg;
    logic [31:0] silence_level_reg;
    logic [15:0] min_age_reg;
    logic [15:0] max_age_reg;

    // Captured item.
    cmd_t        cmd_reg,  cmd_next;
    logic [15:0] note_reg, note_next;
    logic [4:0]  rv_reg,   rv_next;
    logic [31:0] lvl_reg,  lvl_next;

    // Per-voice flags, cleared at once by reset and panic.
    logic [NUM_VOICES-1:0] used_reg, used_next;
    logic [NUM_VOICES-1:0] held_reg, held_next;

    // Scan state.
    logic [IW-1:0] rd_addr_reg,    rd_addr_next;
    logic          rd_valid_reg,   rd_valid_next;
    logic [IW-1:0] cmp_idx_reg,    cmp_idx_next;
    logic          found_reg,      found_next;
    logic [IW-1:0] best_idx_reg,   best_idx_next;
    logic [32:0]   best_score_reg, best_score_next;
    logic [4:0]    rel_cnt_reg,    rel_cnt_next;
    logic          ret_reg,        ret_next;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg,  out_data_next;

    // Voice table memory.
    voice_entry_t mem [NUM_VOICES];
    voice_entry_t rd_data_reg;
    logic         mem_we;
    logic [IW-1:0] mem_waddr;
    voice_entry_t mem_wdata;
    logic         mem_re;
    logic [IW-1:0] mem_raddr;

    logic [IW-1:0] rv_idx;
    logic          rv_in_range;
    logic          cmp_used;
    logic          cmp_held;
    logic [32:0]   score;
    logic [15:0]   new_age;
    logic          retire;
    logic [4:0]    res_voice;
    logic          res_stole;
    logic [4:0]    res_rel;
    logic          res_retired;

    assign rv_idx      = IW'(rv_reg);
    assign rv_in_range = ({4'b0, rv_reg} < 9'(NUM_VOICES));
    assign cmp_used    = used_reg[cmp_idx_reg];
    assign cmp_held    = held_reg[cmp_idx_reg];
    assign score       = {1'b0, rd_data_reg.level}
                       + (cmp_held ? {1'b0, held_bonus_reg} : 33'd0);
    assign new_age     = (rd_data_reg.age == AGE_MAX) ? AGE_MAX : rd_data_reg.age + 16'd1;
    assign retire      = ((new_age > min_age_reg) && (lvl_reg < silence_level_reg))
                       || (new_age > max_age_reg);

    assign res_voice   = (cmd_reg == CMD_NOTE_ON) ? 5'(best_idx_reg)
                       : (cmd_reg == CMD_REPORT)  ? rv_reg : 5'd0;
    assign res_stole   = (cmd_reg == CMD_NOTE_ON) && !found_reg;
    assign res_rel     = (cmd_reg == CMD_NOTE_OFF) ? rel_cnt_reg : 5'd0;
    assign res_retired = (cmd_reg == CMD_REPORT) && ret_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bonus_reg    <= HELD_BONUS_RST;
            silence_level_reg <= SILENCE_LEVEL_RST;
            min_age_reg       <= MIN_AGE_RST;
            max_age_reg       <= MAX_AGE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HELD_BONUS:    held_bonus_reg    <= cfg_data;
                REG_SILENCE_LEVEL: silence_level_reg <= cfg_data;
                REG_MIN_AGE:       min_age_reg       <= cfg_data[15:0];
                REG_MAX_AGE:       max_age_reg       <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        note_next       = note_reg;
        rv_next         = rv_reg;
        lvl_next        = lvl_reg;
        used_next       = used_reg;
        held_next       = held_reg;
        rd_addr_next    = rd_addr_reg;
        rd_valid_next   = cmd.rd_scan;
        cmp_idx_next    = rd_addr_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_score_next = best_score_reg;
        rel_cnt_next    = rel_cnt_reg;
        ret_next        = ret_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = best_idx_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = rd_addr_reg;

        if (cmd.load)
        begin
            cmd_next        = cmd_t'(s_tuser);
            note_next       = s_tdata[15:0];
            rv_next         = s_tdata[20:16];
            lvl_next        = s_tdata[52:21];
            rd_addr_next    = '0;
            found_next      = 1'b0;
            best_idx_next   = '0;
            best_score_next = '0;
            rel_cnt_next    = '0;
            ret_next        = 1'b0;
        end

        if (cmd.rd_scan)
        begin
            mem_re       = 1'b1;
            mem_raddr    = rd_addr_reg;
            rd_addr_next = rd_addr_reg + IW'(1);
        end

        if (cmd.rd_rep)
        begin
            mem_re    = 1'b1;
            mem_raddr = rv_idx;
        end

        // One voice returns from the table each cycle of the scan.
        if (rd_valid_reg)
        begin
            case (cmd_reg)
                CMD_NOTE_ON:
                begin
                    if (!found_reg)
                    begin
                        if (!cmp_used)
                        begin
                            found_next    = 1'b1;
                            best_idx_next = cmp_idx_reg;
                        end
                        else if ((cmp_idx_reg == '0) || (score < best_score_reg))
                        begin
                            best_idx_next   = cmp_idx_reg;
                            best_score_next = score;
                        end
                    end
                end
                CMD_NOTE_OFF:
                begin
                    if (cmp_used && (rd_data_reg.note == note_reg))
                    begin
                        held_next[cmp_idx_reg] = 1'b0;
                        if (rel_cnt_reg != REL_MAX)
                        begin
                            rel_cnt_next = rel_cnt_reg + 5'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.rep_eval)
        begin
            mem_we          = 1'b1;
            mem_waddr       = rv_idx;
            mem_wdata.note  = rd_data_reg.note;
            mem_wdata.age   = new_age;
            mem_wdata.level = lvl_reg;
            if (retire)
            begin
                used_next[rv_idx] = 1'b0;
                ret_next          = 1'b1;
            end
        end

        if (cmd.commit)
        begin
            mem_we                  = 1'b1;
            mem_waddr               = best_idx_reg;
            mem_wdata.note          = note_reg;
            mem_wdata.age           = '0;
            mem_wdata.level         = LEVEL_ONE;
            used_next[best_idx_reg] = 1'b1;
            held_next[best_idx_reg] = 1'b1;
        end

        if (cmd.panic)
        begin
            used_next = '0;
            held_next = '0;
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {4'b0, res_retired, res_rel, res_stole, res_voice};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            held_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            held_reg      <= held_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        note_reg       <= note_next;
        rv_reg         <= rv_next;
        lvl_reg        <= lvl_next;
        rd_addr_reg    <= rd_addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_score_reg <= best_score_next;
        rel_cnt_reg    <= rel_cnt_next;
        ret_reg        <= ret_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.rep_ok    = rv_in_range && used_reg[rv_idx];
    assign stat.scan_last = (rd_addr_reg == IW'(NUM_VOICES - 1));
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ design/voice_allocator_with_stealing.sv @@
// Top level of the polyphonic voice allocator with voice stealing.
// Note on and note off scan the voice table one voice per cycle through its single read port,
// then pass a drain state for the last compare; note on also adds a commit state that
// writes the chosen voice back. A level report reads its voice, then updates it in an evaluate
// state unless it is out of range or free; a panic goes straight to the finish state.
// The result enters the output register as the block becomes ready again; while an earlier
// result is still held back by the receiver, the block waits in its last state before that.
// rst_n clears the voice flags, the handshake state and the settings asynchronously; the
// table contents are not cleared, as the contents of a free voice are never used.
`default_nettype none

module voice_allocator_with_stealing
    import vas_pkg::*;
#(
    parameter int NUM_VOICES = NUM_VOICES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // command
    input  wire logic [1:0]            s_tuser,
    // note_id [15:0], report_voice [20:16], block_level [52:21], zero [55:53]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // voice [4:0], stole [5], released_count [10:6], retired [11], zero [15:12]
    output logic [M_TDATA_W-1:0]       m_tdata
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    vas_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    vas_dp
    #(
        .NUM_VOICES (NUM_VOICES)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

endmodule

`default_nettype wire

@@ design/vas_chk.sv @@
// Port-level checker of the voice allocator and its binding to the top level.
`default_nettype none

module vas_chk
    import vas_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A result beat that is held back keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    // Only one item is taken in at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again straight after a beat");

    // A new result only follows work on an item, never an idle cycle.
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in work");

    // Each result belongs to one command, so its fields do not mix.
    a_fields_apart: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!(m_tdata[5] && m_tdata[11])
                      && ((m_tdata[10:6] == 5'd0)
                          || ((m_tdata[4:0] == 5'd0) && !m_tdata[5] && !m_tdata[11]))))
        else $error("result mixes fields of different commands");

endmodule

bind voice_allocator_with_stealing vas_chk u_vas_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ sim/voice_alloc_checker.sv @@
// Checker for the voice allocator: tracks the voice table, predicts each result and compares it.
`timescale 1ns / 1ps

module voice_alloc_checker
    import vas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [1:0]            s_tuser,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    fail_count,
    output int                    results_outstanding,
    output int                    steal_total,
    output int                    retire_total
);

    localparam int NV = NUM_VOICES_DEF;
    localparam int MAX_REPORTS = 60;

    // Members run from the highest bit down, matching the result beat layout.
    typedef struct packed {
        logic       retired;
        logic [4:0] released;
        logic       stole;
        logic [4:0] voice;
    } voice_result_t;

    logic        used_q  [NV];
    logic        held_q  [NV];
    logic [15:0] note_q  [NV];
    logic [15:0] age_q   [NV];
    logic [31:0] level_q [NV];

    logic [31:0] bonus_q;
    logic [31:0] silence_q;
    logic [15:0] min_age_q;
    logic [15:0] max_age_q;

    voice_result_t expected_results[$];
    int            fails;
    int            steals;
    int            retires;

    function automatic void clear_table();
        for (int i = 0; i < NV; i++)
        begin
            used_q[i]  = 1'b0;
            held_q[i]  = 1'b0;
            note_q[i]  = '0;
            age_q[i]   = '0;
            level_q[i] = '0;
        end
    endfunction

    // Applies one command to the voice table and returns the result it must produce.
    function automatic voice_result_t apply_voice_event(cmd_t cmd, logic [15:0] id,
                                                        logic [4:0] rv, logic [31:0] lvl);
        voice_result_t r;
        logic          found;
        int            pick;
        int            n;
        logic [32:0]   score;
        logic [32:0]   best;
        logic [15:0]   new_age;
        r = '0;
        case (cmd)
            CMD_NOTE_ON:
            begin
                found = 1'b0;
                pick  = 0;
                best  = '1;
                for (int i = 0; i < NV; i++)
                begin
                    if (!found)
                    begin
                        if (!used_q[i])
                        begin
                            found = 1'b1;
                            pick  = i;
                        end
                        else
                        begin
                            // The sum is 33 bits wide so that a large bonus never wraps.
                            score = {1'b0, level_q[i]} + (held_q[i] ? {1'b0, bonus_q} : 33'd0);
                            if (i == 0 || score < best)
                            begin
                                best = score;
                                pick = i;
                            end
                        end
                    end
                end
                used_q[pick]  = 1'b1;
                held_q[pick]  = 1'b1;
                note_q[pick]  = id;
                age_q[pick]   = '0;
                level_q[pick] = LEVEL_ONE;
                r.voice = pick[4:0];
                r.stole = !found;
            end
            CMD_NOTE_OFF:
            begin
                n = 0;
                for (int i = 0; i < NV; i++)
                begin
                    if (used_q[i] && note_q[i] == id)
                    begin
                        held_q[i] = 1'b0;
                        n++;
                    end
                end
                r.released = (n > 31) ? REL_MAX : n[4:0];
            end
            CMD_PANIC:
                clear_table();
            default:
            begin
                r.voice = rv;
                if (rv < NV && used_q[rv])
                begin
                    new_age = (age_q[rv] == AGE_MAX) ? AGE_MAX : age_q[rv] + 16'd1;
                    age_q[rv]   = new_age;
                    level_q[rv] = lvl;
                    if ((new_age > min_age_q && lvl < silence_q) || new_age > max_age_q)
                    begin
                        used_q[rv] = 1'b0;
                        r.retired  = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("%0t: result %s mismatch, expected %0d actual %0d",
                         $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        voice_result_t want;
        voice_result_t got;
        if (!rst_n)
        begin
            clear_table();
            bonus_q   = HELD_BONUS_RST;
            silence_q = SILENCE_LEVEL_RST;
            min_age_q = MIN_AGE_RST;
            max_age_q = MAX_AGE_RST;
            expected_results.delete();
            fails   = 0;
            steals  = 0;
            retires = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_HELD_BONUS:    bonus_q   = cfg_data;
                    REG_SILENCE_LEVEL: silence_q = cfg_data;
                    REG_MIN_AGE:       min_age_q = cfg_data[15:0];
                    default:           max_age_q = cfg_data[15:0];
                endcase
            end
            // An outgoing beat always belongs to an earlier input beat, so compare first.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[11:0];
                if (expected_results.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result beat, expected none actual 0x%h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("voice", want.voice, got.voice);
                    check_field("stole", want.stole, got.stole);
                    check_field("released_count", want.released, got.released);
                    check_field("retired", want.retired, got.retired);
                    check_field("padding", 0, m_tdata[15:12]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = apply_voice_event(cmd_t'(s_tuser), s_tdata[15:0], s_tdata[20:16],
                                         s_tdata[52:21]);
                if (want.stole)
                    steals++;
                if (want.retired)
                    retires++;
                expected_results.push_back(want);
            end
        end
        fail_count          <= fails;
        results_outstanding <= expected_results.size();
        steal_total         <= steals;
        retire_total        <= retires;
    end

endmodule

@@ sim/testbench.sv @@
// Top of the voice allocator testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
    import vas_pkg::*;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int PHASE_BEATS    = 160;
    localparam int NUM_PHASES     = 7;
    localparam int RX_HOLD_CYCLES = 300;

    typedef struct {
        logic [31:0] bonus;
        logic [31:0] silence;
        logic [15:0] min_age;
        logic [15:0] max_age;
    } reg_set_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [1:0]            s_tuser = '0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int fail_count;
    int results_outstanding;
    int steal_total;
    int retire_total;
    int cycle_count = 0;
    int beats_sent = 0;
    int settings_used = 1;
    int tx_burst_left = 0;
    bit rx_hold_req = 1'b0;

    voice_allocator_with_stealing dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    voice_alloc_checker alloc_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tuser             (s_tuser),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .fail_count          (fail_count),
        .results_outstanding (results_outstanding),
        .steal_total         (steal_total),
        .retire_total        (retire_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out after %0d cycles", $time, cycle_count);
            $display("[voice_allocator_with_stealing] ERROR");
            $finish;
        end
    end

    function automatic int next_gap();
        if (tx_burst_left > 0)
        begin
            tx_burst_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            tx_burst_left = $urandom_range(10, 40);
        return $urandom_range(0, 10);
    endfunction

    // Note ids come mostly from a small pool so that note-offs hit several voices.
    function automatic logic [15:0] rand_note();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'h00FF;
            3:       return 16'h8000;
            4:       return 16'hFFFF;
            5:       return 16'h1234;
            6:       return 16'hABCD;
            default: return 16'h5A5A;
        endcase
    endfunction

    function automatic logic [31:0] rand_level();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 32);
            3:       return LEVEL_ONE;
            4:       return $urandom_range(0, 32'h0200_0000);
            default: return $urandom;
        endcase
    endfunction

    // Offers one beat after a random gap; tvalid is left high for a following beat.
    task automatic send_beat(cmd_t cmd, logic [15:0] id, logic [4:0] rv, logic [31:0] lvl);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, lvl, rv, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    // The outstanding count is registered in the checker, so look at it only after the next edge.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(reg_set_t rs);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HELD_BONUS;
        cfg_data  <= rs.bonus;
        @(posedge clk);
        cfg_index <= REG_SILENCE_LEVEL;
        cfg_data  <= rs.silence;
        @(posedge clk);
        cfg_index <= REG_MIN_AGE;
        cfg_data  <= {16'($urandom), rs.min_age};
        @(posedge clk);
        cfg_index <= REG_MAX_AGE;
        cfg_data  <= {16'($urandom), rs.max_age};
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic reg_set_t phase_settings(int phase);
        reg_set_t rs;
        case (phase)
            1:       rs = '{32'h0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF};
            2:       rs = '{32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'd0};
            3:       rs = '{$urandom, 32'h0080_0000, 16'd2, 16'd6};
            4:       rs = '{LEVEL_ONE, $urandom, 16'hFFFF, 16'hFFFF};
            5:       rs = '{$urandom, $urandom, 16'($urandom_range(0, 8)),
                            16'($urandom_range(0, 12))};
            default: rs = '{HELD_BONUS_RST, SILENCE_LEVEL_RST, MIN_AGE_RST, MAX_AGE_RST};
        endcase
        return rs;
    endfunction

    task automatic run_sequence();
        int          kind;
        int          count;
        logic [15:0] base_id;
        logic [4:0]  rv;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            // Fill the table, often past full so that voices are stolen.
            count   = $urandom_range(4, 30);
            base_id = rand_note();
            repeat (count)
                send_beat(CMD_NOTE_ON, $urandom_range(0, 1) ? base_id : rand_note(), '0, '0);
        end
        else if (kind < 52)
        begin
            count = $urandom_range(2, 12);
            repeat (count)
            begin
                rv = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                                 : 5'($urandom_range(0, 23));
                send_beat(CMD_REPORT, rand_note(), rv, rand_level());
            end
        end
        else if (kind < 70)
            send_beat(CMD_NOTE_OFF, rand_note(), 5'($urandom), $urandom);
        else if (kind < 75)
            send_beat(CMD_PANIC, 16'($urandom), 5'($urandom), $urandom);
        else if (kind < 90)
            send_beat(CMD_NOTE_ON, rand_note(), 5'($urandom), $urandom);
        else
            send_beat(cmd_t'($urandom_range(0, 3)), 16'($urandom), 5'($urandom), $urandom);
    endtask

    // Receiver: random stalls per beat, bursts with no stall, and one long hold-off on request.
    initial
    begin
        int stall;
        int burst_left;
        burst_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            if (burst_left > 0)
            begin
                stall = 0;
                burst_left--;
            end
            else
            begin
                stall = $urandom_range(0, 10);
                if ($urandom_range(0, 24) == 0)
                    burst_left = $urandom_range(10, 40);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        int target;
        wait (rst_n === 1'b1);

        // Directed opening at the reset settings: empty table, out-of-range and free-voice
        // reports, a small allocation, a note-off hitting two voices and panic.
        send_beat(CMD_NOTE_OFF, 16'h0000, '0, '0);
        send_beat(CMD_REPORT, 16'h0000, 5'd0, 32'h0);
        send_beat(CMD_REPORT, 16'hFFFF, 5'd24, LEVEL_ONE);
        send_beat(CMD_REPORT, 16'h0000, 5'd31, 32'hFFFF_FFFF);
        send_beat(CMD_PANIC, 16'hFFFF, 5'd31, 32'hFFFF_FFFF);
        send_beat(CMD_NOTE_ON, 16'h0000, '0, '0);
        send_beat(CMD_NOTE_ON, 16'hFFFF, '0, '0);
        send_beat(CMD_NOTE_ON, 16'hFFFF, '0, '0);
        send_beat(CMD_NOTE_OFF, 16'hFFFF, '0, '0);
        send_beat(CMD_REPORT, 16'h0000, 5'd1, 32'h0);
        send_beat(CMD_REPORT, 16'h0000, 5'd2, 32'hFFFF_FFFF);
        send_beat(CMD_NOTE_OFF, 16'h8000, '0, '0);
        send_beat(CMD_NOTE_ON, 16'h8000, '0, '0);
        send_beat(CMD_REPORT, 16'h8000, 5'd3, LEVEL_ONE);
        send_beat(CMD_REPORT, 16'h8000, 5'd23, 32'h0000_0010);
        send_beat(CMD_PANIC, 16'h0000, '0, '0);
        send_beat(CMD_NOTE_ON, 16'h1234, '0, '0);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_idle();
                load_settings(phase_settings(phase));
            end
            if (phase == 2)
            begin
                // Hold the output off while the sender keeps offering beats back to back.
                rx_hold_req   = 1'b1;
                tx_burst_left = 12;
            end
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
                run_sequence();
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Run covered %0d beats under %0d register settings.",
                 beats_sent, settings_used);
        $display("Predicted %0d voice steals and %0d retirements.",
                 steal_total, retire_total);
        if (fail_count == 0 && results_outstanding == 0)
            $display("[voice_allocator_with_stealing] OK");
        else
            $display("[voice_allocator_with_stealing] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
design/vas_pkg.sv
design/vas_ctrl.sv
design/vas_dp.sv
design/voice_allocator_with_stealing.sv
design/vas_chk.sv
sim/voice_alloc_checker.sv
sim/testbench.sv
